@@ design/servo_slew_pulse_generator_macros.svh @@
// ----------------------------------------------------------------------------
// Servo slew pulse generator assertion macros
// Concurrent assertion wrappers shared by the design files.
// ----------------------------------------------------------------------------
`ifndef SERVO_SLEW_PULSE_GENERATOR_MACROS_SVH
`define SERVO_SLEW_PULSE_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset
`define SSPG_ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SSPG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSPG_ASSERT_DIS(label, clk, rst, prop, msg)
`define SSPG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ design/sspg_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo slew pulse generator package
// Command codes, register indexes, sequencer states and reset values.
// ----------------------------------------------------------------------------
package sspg_pkg;

   // Width of the pulse result and of the divider quotient
   localparam int PULSE_WIDTH    = 16;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_SET   = 2'd1,
      CMD_ADD   = 2'd2,
      CMD_PLACE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_PHYS_RANGE    = 3'd0,
      REG_ZERO_OFFSET   = 3'd1,
      REG_REVERSE       = 3'd2,
      REG_LIMIT_MIN     = 3'd3,
      REG_LIMIT_MAX     = 3'd4,
      REG_PULSE_MIN     = 3'd5,
      REG_PULSE_MAX     = 3'd6,
      REG_STEP_PER_TICK = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TARGET,
      ST_MAG,
      ST_LIMIT,
      ST_MOVE,
      ST_OFFSET,
      ST_MIRROR,
      ST_CLAMP,
      ST_MUL_BASE,
      ST_MUL_SPAN,
      ST_SUM,
      ST_DIVIDEND,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Register reset values
   localparam logic [8:0]  PHYS_RANGE_RESET  = 9'd180;
   localparam logic [7:0]  ZERO_OFFSET_RESET = 8'd0;
   localparam logic        REVERSE_RESET     = 1'b0;
   localparam logic [8:0]  LIMIT_MIN_RESET   = 9'h1A6;  // -90
   localparam logic [8:0]  LIMIT_MAX_RESET   = 9'd90;
   localparam logic [15:0] PULSE_MIN_RESET   = 16'd500;
   localparam logic [15:0] PULSE_MAX_RESET   = 16'd2500;
   localparam logic [15:0] STEP_RESET        = 16'd768;

endpackage

@@ design/servo_slew_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// Servo slew pulse generator
// One servo channel: slew-limited current angle, clamped target and the
// servo pulse width for the current angle.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_tvalid/req_tready  tuser cmd, tdata angle
//  rsp_      out        rsp_tvalid/rsp_tready  tdata pulse_us, current_deg,
//                                              at_target
//  csr_      in/out     APB psel/penable       eight config registers
//
//  A request runs through the sequencer states to its result, a tick also
//  through the slew states; the next request is taken the cycle after the
//  result is loaded. The 16-step restoring divider takes most of that time.
//  Reset is synchronous: it restores register defaults, zeroes both angles
//  and empties the result register. A stalled result holds in the output
//  register; the next request is still taken meanwhile.
// ----------------------------------------------------------------------------
`include "servo_slew_pulse_generator_macros.svh"

module servo_slew_pulse_generator #(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [9:0] angle
   input  logic [1:0]                          req_tuser,  // [1:0] cmd
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [15:0] pulse_us,
                                                           // [25:16] current_deg,
                                                           // [26] at_target
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sspg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [sspg_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [sspg_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int F   = ANGLE_FRAC_BITS;
   localparam int CW  = F + 10;                 // current angle
   localparam int DW  = F + 9;                  // physical range in Q
   localparam int OW  = F + 12;                 // output angle before clamp
   localparam int DFW = F + 11;                 // distance to target
   localparam int MSW = (DFW > 16) ? DFW : 16;  // step compare
   localparam int SW  = 17;                     // pulse span
   localparam int MAW = DW + 1;
   localparam int PW  = MAW + SW;
   localparam int NW  = DW + 17;                // dividend
   localparam int VW  = DW + 1;                 // divisor
   localparam int QW  = sspg_pkg::PULSE_WIDTH;

   localparam logic signed [CW-1:0] CUR_LO = $signed({10'h300, {F{1'b0}}});
   localparam logic signed [CW-1:0] CUR_HI = $signed({10'h0FF, {F{1'b0}}});
   localparam logic signed [CW:0]   HALF_Q = $signed((CW+1)'(1) << (F - 1));

   // configuration registers
   logic [8:0]  phys_ff,  phys_in;
   logic [7:0]  off_ff,   off_in;
   logic        rev_ff,   rev_in;
   logic [8:0]  lmin_ff,  lmin_in;
   logic [8:0]  lmax_ff,  lmax_in;
   logic [15:0] pmin_ff,  pmin_in;
   logic [15:0] pmax_ff,  pmax_in;
   logic [15:0] step_ff,  step_in;
   logic        cfg_wr;
   sspg_pkg::reg_index_type cfg_idx;

   // sequencer and datapath
   sspg_pkg::state_type state_ff, state_in;
   sspg_pkg::cmd_type   cmd_ff,   cmd_in;
   logic signed [9:0]     ang_ff,   ang_in;
   logic signed [9:0]     tgt_ff,   tgt_in;
   logic signed [CW-1:0]  cur_ff,   cur_in;
   logic signed [DFW-1:0] diff_ff,  diff_in;
   logic [DFW-1:0]        mag_ff,   mag_in;
   logic                  neg_ff,   neg_in;
   logic [DFW-1:0]        stp_ff,   stp_in;
   logic signed [OW-1:0]  out_ff,   out_in;
   logic [DW-1:0]         oclip_ff, oclip_in;
   logic signed [SW-1:0]  span_ff,  span_in;
   logic signed [PW-1:0]  prod_ff,  prod_in;
   logic signed [PW-1:0]  num_ff,   num_in;
   logic signed [9:0]     deg_ff,   deg_in;
   logic                  at_ff,    at_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff,  rsp_data_in;
   logic                  rsp_load;

   // combinational pieces
   logic [DW-1:0]         d_q;
   logic signed [10:0]    sum_t, lo_t, hi_t, raised_t, clamped_t;
   logic signed [DFW:0]   cur_ext, stp_s, move_t;
   logic [MSW-1:0]        step_ext, mag_ext;
   logic signed [8:0]     off9, offn;
   logic signed [OW-1:0]  out_raw, d_ext;
   logic signed [CW:0]    round_v;
   logic signed [10:0]    deg_t;
   logic                  deg_adj;
   logic signed [MAW-1:0] mul_a;
   logic signed [SW-1:0]  mul_b;
   logic signed [PW-1:0]  mul_p;
   logic                  div_start, div_done;
   logic [NW-1:0]         div_dividend;
   logic [QW-1:0]         div_quotient;
   logic [15:0]           pulse;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_idx    = sspg_pkg::reg_index_type'(csr_paddr[4:2]);

   // Write the addressed register
   always_comb begin
      phys_in = phys_ff;
      off_in  = off_ff;
      rev_in  = rev_ff;
      lmin_in = lmin_ff;
      lmax_in = lmax_ff;
      pmin_in = pmin_ff;
      pmax_in = pmax_ff;
      step_in = step_ff;
      if (cfg_wr) begin
         unique case (cfg_idx)
            sspg_pkg::REG_PHYS_RANGE:    phys_in = csr_pwdata[8:0];
            sspg_pkg::REG_ZERO_OFFSET:   off_in  = csr_pwdata[7:0];
            sspg_pkg::REG_REVERSE:       rev_in  = csr_pwdata[0];
            sspg_pkg::REG_LIMIT_MIN:     lmin_in = csr_pwdata[8:0];
            sspg_pkg::REG_LIMIT_MAX:     lmax_in = csr_pwdata[8:0];
            sspg_pkg::REG_PULSE_MIN:     pmin_in = csr_pwdata[15:0];
            sspg_pkg::REG_PULSE_MAX:     pmax_in = csr_pwdata[15:0];
            sspg_pkg::REG_STEP_PER_TICK: step_in = csr_pwdata[15:0];
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (cfg_idx)
         sspg_pkg::REG_PHYS_RANGE:    csr_prdata = {23'd0, phys_ff};
         sspg_pkg::REG_ZERO_OFFSET:   csr_prdata = {24'd0, off_ff};
         sspg_pkg::REG_REVERSE:       csr_prdata = {31'd0, rev_ff};
         sspg_pkg::REG_LIMIT_MIN:     csr_prdata = {23'd0, lmin_ff};
         sspg_pkg::REG_LIMIT_MAX:     csr_prdata = {23'd0, lmax_ff};
         sspg_pkg::REG_PULSE_MIN:     csr_prdata = {16'd0, pmin_ff};
         sspg_pkg::REG_PULSE_MAX:     csr_prdata = {16'd0, pmax_ff};
         sspg_pkg::REG_STEP_PER_TICK: csr_prdata = {16'd0, step_ff};
      endcase
   end

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         sspg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = sspg_pkg::ST_TARGET;
         end
         sspg_pkg::ST_TARGET: begin
            state_in = (cmd_ff == sspg_pkg::CMD_TICK) ? sspg_pkg::ST_MAG
                                                       : sspg_pkg::ST_OFFSET;
         end
         sspg_pkg::ST_MAG:      state_in = sspg_pkg::ST_LIMIT;
         sspg_pkg::ST_LIMIT:    state_in = sspg_pkg::ST_MOVE;
         sspg_pkg::ST_MOVE:     state_in = sspg_pkg::ST_OFFSET;
         sspg_pkg::ST_OFFSET:   state_in = sspg_pkg::ST_MIRROR;
         sspg_pkg::ST_MIRROR:   state_in = sspg_pkg::ST_CLAMP;
         sspg_pkg::ST_CLAMP:    state_in = sspg_pkg::ST_MUL_BASE;
         sspg_pkg::ST_MUL_BASE: state_in = sspg_pkg::ST_MUL_SPAN;
         sspg_pkg::ST_MUL_SPAN: state_in = sspg_pkg::ST_SUM;
         sspg_pkg::ST_SUM:      state_in = sspg_pkg::ST_DIVIDEND;
         sspg_pkg::ST_DIVIDEND: begin
            div_start = 1'b1;
            state_in  = sspg_pkg::ST_DIVIDE;
         end
         sspg_pkg::ST_DIVIDE: begin
            if (div_done) state_in = sspg_pkg::ST_DONE;
         end
         sspg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = sspg_pkg::ST_IDLE;
            end
         end
         default: state_in = sspg_pkg::ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------- datapath
   assign d_q = {phys_ff, {F{1'b0}}};

   // Target: add or take, then raise to the low limit and cap at the high
   assign sum_t     = (cmd_ff == sspg_pkg::CMD_ADD) ? (11'(tgt_ff) + 11'(ang_ff))
                                                    : 11'(ang_ff);
   assign lo_t      = 11'($signed(lmin_ff));
   assign hi_t      = 11'($signed(lmax_ff));
   assign raised_t  = (sum_t < lo_t) ? lo_t : sum_t;
   assign clamped_t = (raised_t > hi_t) ? hi_t : raised_t;

   // Tick: move by the smaller of step and remaining distance
   assign step_ext = MSW'(step_ff);
   assign mag_ext  = MSW'(mag_ff);
   assign cur_ext  = (DFW+1)'(cur_ff);
   assign stp_s    = $signed({1'b0, stp_ff});
   assign move_t   = neg_ff ? (cur_ext - stp_s) : (cur_ext + stp_s);

   // Output angle: current plus offset plus half the range
   assign off9    = 9'($signed(off_ff));
   assign offn    = rev_ff ? -off9 : off9;
   assign out_raw = OW'(cur_ff) + OW'($signed({offn, {F{1'b0}}}))
                  + $signed(OW'({phys_ff, {(F-1){1'b0}}}));
   assign d_ext   = $signed(OW'(d_q));

   // Rounded degrees, truncated toward zero
   assign round_v = (CW+1)'(cur_ff) + HALF_Q;
   assign deg_adj = round_v[CW] & (|round_v[F-1:0]);
   assign deg_t   = $signed(round_v[CW:F]) + $signed(11'(deg_adj));

   // Shared multiplier: base pulse, then span times angle
   assign mul_a = (state_ff == sspg_pkg::ST_MUL_SPAN) ? $signed({1'b0, oclip_ff})
                                                      : $signed(MAW'(phys_ff));
   assign mul_b = (state_ff == sspg_pkg::ST_MUL_SPAN) ? span_ff
                                                      : $signed({1'b0, pmin_ff});
   assign mul_p = mul_a * mul_b;

   // Rounded numerator 2*num + d, negative numerators taken as zero
   assign div_dividend = num_ff[PW-1] ? NW'(d_q)
                                      : ({num_ff[NW-2:0], 1'b0} + NW'(d_q));

   always_comb begin
      cmd_in   = cmd_ff;
      ang_in   = ang_ff;
      tgt_in   = tgt_ff;
      cur_in   = cur_ff;
      diff_in  = diff_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      stp_in   = stp_ff;
      out_in   = out_ff;
      oclip_in = oclip_ff;
      span_in  = span_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      deg_in   = deg_ff;
      at_in    = at_ff;
      unique case (state_ff)
         sspg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = sspg_pkg::cmd_type'(req_tuser);
               ang_in = $signed(req_tdata[9:0]);
            end
         end
         sspg_pkg::ST_TARGET: begin
            if (cmd_ff != sspg_pkg::CMD_TICK) tgt_in = clamped_t[9:0];
            if (cmd_ff == sspg_pkg::CMD_PLACE) begin
               cur_in = $signed({clamped_t[9:0], {F{1'b0}}});
            end
            diff_in = DFW'($signed({tgt_ff, {F{1'b0}}})) - DFW'(cur_ff);
         end
         sspg_pkg::ST_MAG: begin
            neg_in = diff_ff[DFW-1];
            mag_in = diff_ff[DFW-1] ? $unsigned(-diff_ff) : $unsigned(diff_ff);
         end
         sspg_pkg::ST_LIMIT: begin
            stp_in = (step_ext > mag_ext) ? mag_ff : step_ext[DFW-1:0];
         end
         sspg_pkg::ST_MOVE: begin
            cur_in = move_t[CW-1:0];
         end
         sspg_pkg::ST_OFFSET: begin
            out_in  = out_raw;
            span_in = $signed({1'b0, pmax_ff}) - $signed({1'b0, pmin_ff});
            deg_in  = deg_t[9:0];
            at_in   = (cur_ff == $signed({tgt_ff, {F{1'b0}}}));
         end
         sspg_pkg::ST_MIRROR: begin
            if (rev_ff) out_in = d_ext - out_ff;
         end
         sspg_pkg::ST_CLAMP: begin
            if (out_ff[OW-1]) begin
               oclip_in = '0;
            end else if (out_ff > d_ext) begin
               oclip_in = d_q;
            end else begin
               oclip_in = out_ff[DW-1:0];
            end
         end
         sspg_pkg::ST_MUL_BASE: begin
            prod_in = mul_p;
         end
         sspg_pkg::ST_MUL_SPAN: begin
            num_in  = prod_ff <<< F;
            prod_in = mul_p;
         end
         sspg_pkg::ST_SUM: begin
            num_in = num_ff + prod_ff;
         end
         default: begin
         end
      endcase
   end

   sspg_divider #(
      .DVD_WIDTH (NW),
      .DVS_WIDTH (VW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ({phys_ff, {(F+1){1'b0}}}),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // A zero range gives the base pulse
   assign pulse = (phys_ff == '0) ? pmin_ff : div_quotient;

   // Output register: hold until taken
   assign rsp_data_in  = rsp_load ? {5'd0, at_ff, deg_ff, pulse} : rsp_data_ff;
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_ff      <= sspg_pkg::PHYS_RANGE_RESET;
         off_ff       <= sspg_pkg::ZERO_OFFSET_RESET;
         rev_ff       <= sspg_pkg::REVERSE_RESET;
         lmin_ff      <= sspg_pkg::LIMIT_MIN_RESET;
         lmax_ff      <= sspg_pkg::LIMIT_MAX_RESET;
         pmin_ff      <= sspg_pkg::PULSE_MIN_RESET;
         pmax_ff      <= sspg_pkg::PULSE_MAX_RESET;
         step_ff      <= sspg_pkg::STEP_RESET;
         state_ff     <= sspg_pkg::ST_IDLE;
         tgt_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phys_ff      <= phys_in;
         off_ff       <= off_in;
         rev_ff       <= rev_in;
         lmin_ff      <= lmin_in;
         lmax_ff      <= lmax_in;
         pmin_ff      <= pmin_in;
         pmax_ff      <= pmax_in;
         step_ff      <= step_in;
         state_ff     <= state_in;
         tgt_ff       <= tgt_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      ang_ff      <= ang_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      stp_ff      <= stp_in;
      out_ff      <= out_in;
      oclip_ff    <= oclip_in;
      span_ff     <= span_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      deg_ff      <= deg_in;
      at_ff       <= at_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SSPG_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!rsp_tvalid && req_tready), "block not idle after reset")
   `SSPG_ASSERT_DIS(a_accept_busy, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "request taken while busy")
   `SSPG_ASSERT_DIS(a_cur_range, clock, reset, (cur_ff >= CUR_LO) && (cur_ff <= CUR_HI), "current angle out of range")
   `SSPG_ASSERT_DIS(a_tgt_range, clock, reset, tgt_ff[9] == tgt_ff[8], "target angle out of range")

endmodule

@@ design/sspg_divider.sv @@
// ----------------------------------------------------------------------------
// Servo slew pulse generator divider
// Restoring divider, one quotient bit per cycle, quotient known to fit
// PULSE_WIDTH bits.
// ----------------------------------------------------------------------------
`include "servo_slew_pulse_generator_macros.svh"

module sspg_divider #(
   parameter int DVD_WIDTH = 34,
   parameter int DVS_WIDTH = 18
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [DVD_WIDTH-1:0]               dividend,
   input  logic [DVS_WIDTH-1:0]               divisor,
   output logic [sspg_pkg::PULSE_WIDTH-1:0]   quotient,
   output logic                               done
);

   localparam int QW   = sspg_pkg::PULSE_WIDTH;
   localparam int SHW  = DVS_WIDTH + QW - 1;
   localparam int CMPW = (SHW > DVD_WIDTH) ? SHW : DVD_WIDTH;
   localparam int CNTW = $clog2(QW);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [DVD_WIDTH-1:0] rem_ff, rem_in;
   logic [SHW-1:0]       dvs_ff, dvs_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [CMPW:0]        trial;
   logic                 fits;

   // Trial subtract of the shifted divisor
   assign trial = {1'b0, CMPW'(rem_ff)} - {1'b0, CMPW'(dvs_ff)};
   assign fits  = !trial[CMPW];

   // Load on start, then one bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dvs_in  = {divisor, {(QW-1){1'b0}}};
      end else if (busy_ff) begin
         rem_in = fits ? trial[DVD_WIDTH-1:0] : rem_ff;
         quo_in = {quo_ff[QW-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

   `SSPG_ASSERT_DIS(a_start_busy, clock, reset, start |=> busy_ff, "divider not busy after start")
   `SSPG_ASSERT_DIS(a_fall_done, clock, reset, $fell(busy_ff) |-> done_ff, "divider ended without done")
   `SSPG_ASSERT_DIS(a_quot_fits, clock, reset, (start && (divisor != '0)) |-> ((dividend >> QW) < divisor), "quotient would overflow")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo slew pulse generator testbench
// Drives tick, set, add and place requests through the stream port with
// random idling on both sides, reprograms the channel over APB between
// phases, and checks every result against a cycle-free model of the channel.
// ----------------------------------------------------------------------------
module tb;

   localparam int     ANGLE_FRAC_BITS = 8;
   localparam longint Q_ONE           = longint'(1) << ANGLE_FRAC_BITS;
   localparam int     PHASES          = 10;
   localparam int     ITEMS_PER_PHASE = 78;
   localparam int     PRESSURE_CYCLES = 400;
   localparam int     STALL_LIMIT     = 4000;

   typedef struct packed {
      logic [8:0]  travel_deg;
      logic [7:0]  zero_offset;
      logic        reverse;
      logic [8:0]  floor_deg;
      logic [8:0]  ceil_deg;
      logic [15:0] width_lo_us;
      logic [15:0] width_hi_us;
      logic [15:0] step_per_tick;
   } servo_cfg_type;

   typedef struct packed {
      logic [15:0] pulse_us;
      logic [9:0]  current_deg;
      logic        at_target;
   } servo_result_type;

   localparam servo_cfg_type RESET_CFG = '{
      travel_deg:    sspg_pkg::PHYS_RANGE_RESET,
      zero_offset:   sspg_pkg::ZERO_OFFSET_RESET,
      reverse:       sspg_pkg::REVERSE_RESET,
      floor_deg:     sspg_pkg::LIMIT_MIN_RESET,
      ceil_deg:      sspg_pkg::LIMIT_MAX_RESET,
      width_lo_us:   sspg_pkg::PULSE_MIN_RESET,
      width_hi_us:   sspg_pkg::PULSE_MAX_RESET,
      step_per_tick: sspg_pkg::STEP_RESET
   };

   // Channel state, settings and the pulses still owed by the block
   class servo_pulse_tracker_type;
      servo_cfg_type    cfg = RESET_CFG;
      longint           current_q = 0;
      longint           target_deg = 0;
      servo_result_type pending_pulses[$];
      int               mismatches = 0;

      function void set_register(sspg_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            sspg_pkg::REG_PHYS_RANGE:    cfg.travel_deg    = value[8:0];
            sspg_pkg::REG_ZERO_OFFSET:   cfg.zero_offset   = value[7:0];
            sspg_pkg::REG_REVERSE:       cfg.reverse       = value[0];
            sspg_pkg::REG_LIMIT_MIN:     cfg.floor_deg     = value[8:0];
            sspg_pkg::REG_LIMIT_MAX:     cfg.ceil_deg      = value[8:0];
            sspg_pkg::REG_PULSE_MIN:     cfg.width_lo_us   = value[15:0];
            sspg_pkg::REG_PULSE_MAX:     cfg.width_hi_us   = value[15:0];
            sspg_pkg::REG_STEP_PER_TICK: cfg.step_per_tick = value[15:0];
            default: ;
         endcase
      endfunction

      // Raise to the low limit first, so the high limit wins when crossed
      function longint clamp_deg(longint a);
         longint lo, hi;
         lo = longint'($signed(cfg.floor_deg));
         hi = longint'($signed(cfg.ceil_deg));
         if (a < lo) a = lo;
         if (a > hi) a = hi;
         return a;
      endfunction

      function void note_command(sspg_pkg::cmd_type cmd, logic [9:0] angle_field);
         longint           angle, diff, mag, step, phys, off, pmin, span, d, pos, num, v;
         servo_result_type res;
         angle = longint'($signed(angle_field));
         case (cmd)
            sspg_pkg::CMD_SET: target_deg = clamp_deg(angle);
            sspg_pkg::CMD_ADD: target_deg = clamp_deg(target_deg + angle);
            sspg_pkg::CMD_PLACE: begin
               target_deg = clamp_deg(angle);
               current_q  = target_deg * Q_ONE;
            end
            default: begin
               // slew toward the target, landing on it when within one step
               diff = target_deg * Q_ONE - current_q;
               mag  = (diff < 0) ? -diff : diff;
               step = longint'(cfg.step_per_tick);
               if (step > mag) step = mag;
               current_q += (diff > 0) ? step : -step;
            end
         endcase

         // pulse width for the updated angle
         phys = longint'(cfg.travel_deg);
         off  = longint'($signed(cfg.zero_offset));
         pmin = longint'(cfg.width_lo_us);
         span = longint'(cfg.width_hi_us) - pmin;
         d    = phys * Q_ONE;
         if (d == 0) begin
            res.pulse_us = cfg.width_lo_us;
         end else begin
            if (cfg.reverse) off = -off;
            pos = current_q + off * Q_ONE + phys * (Q_ONE / 2);
            if (cfg.reverse) pos = d - pos;
            if (pos < 0) pos = 0;
            else if (pos > d) pos = d;
            num = pmin * d + pos * span;
            if (num < 0) num = 0;
            num = (2 * num + d) / (2 * d);
            res.pulse_us = num[15:0];
         end

         // rounding by adding a half and truncating toward zero
         v = (current_q + Q_ONE / 2) / Q_ONE;
         res.current_deg = v[9:0];
         res.at_target   = (current_q == target_deg * Q_ONE);
         pending_pulses.push_back(res);
      endfunction

      function void check_result(logic [31:0] word);
         servo_result_type want;
         if (pending_pulses.size() == 0) begin
            mismatches++;
            $display("%0t: result %h arrived with no request outstanding", $time, word);
            return;
         end
         want = pending_pulses.pop_front();
         if (word[15:0] !== want.pulse_us) begin
            mismatches++;
            $display("%0t: pulse_us expected %0d actual %0d",
                     $time, want.pulse_us, word[15:0]);
         end
         if (word[25:16] !== want.current_deg) begin
            mismatches++;
            $display("%0t: current_deg expected %0d actual %0d",
                     $time, $signed(want.current_deg), $signed(word[25:16]));
         end
         if (word[26] !== want.at_target) begin
            mismatches++;
            $display("%0t: at_target expected %0b actual %0b",
                     $time, want.at_target, word[26]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [9:0] angle
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [15:0] pulse_us, [25:16] current_deg, [26] at_target
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [sspg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [sspg_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [sspg_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   servo_pulse_tracker_type tracker = new;
   bit feed_idle_on      = 1'b1;
   bit sink_idle_on      = 1'b1;
   bit sink_hold_request = 1'b0;

   always #2 clock = ~clock;

   servo_slew_pulse_generator #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 15));
      return int'($urandom_range(30, 80));
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic send_command(sspg_pkg::cmd_type cmd, logic [9:0] angle);
      int gap;
      gap = feed_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, angle};
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_command(cmd, angle);
   endtask

   task automatic write_reg(sspg_pkg::reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      tracker.set_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(servo_cfg_type c);
      write_reg(sspg_pkg::REG_PHYS_RANGE,    {23'd0, c.travel_deg});
      write_reg(sspg_pkg::REG_ZERO_OFFSET,   {24'd0, c.zero_offset});
      write_reg(sspg_pkg::REG_REVERSE,       {31'd0, c.reverse});
      write_reg(sspg_pkg::REG_LIMIT_MIN,     {23'd0, c.floor_deg});
      write_reg(sspg_pkg::REG_LIMIT_MAX,     {23'd0, c.ceil_deg});
      write_reg(sspg_pkg::REG_PULSE_MIN,     {16'd0, c.width_lo_us});
      write_reg(sspg_pkg::REG_PULSE_MAX,     {16'd0, c.width_hi_us});
      write_reg(sspg_pkg::REG_STEP_PER_TICK, {16'd0, c.step_per_tick});
   endtask

   // Drop the request line and wait until every owed result is in
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending_pulses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic servo_cfg_type phase_config(int p);
      servo_cfg_type c;
      int            lo, hi, t;
      case (p)
         1: c = '{9'd511, 8'sd127, 1'b1, 9'h100, 9'd255, 16'hFFFF, 16'd0, 16'hFFFF};
         // no travel, crossed limits, frozen slew
         2: c = '{9'd0, 8'h80, 1'b0, 9'd255, 9'h100, 16'd0, 16'hFFFF, 16'd0};
         3: c = '{9'd180, 8'd0, 1'b0, 9'h1A6, 9'd90, 16'd500, 16'd2500, 16'd100};
         4: begin
            c = RESET_CFG;
            c.travel_deg    = 9'd1;
            c.step_per_tick = 16'd1;
            c.reverse       = 1'b1;
         end
         default: begin
            lo = int'($urandom_range(0, 360)) - 180;
            hi = int'($urandom_range(0, 360)) - 180;
            if (lo > hi && $urandom_range(0, 3) != 0) begin
               t  = lo;
               lo = hi;
               hi = t;
            end
            c.travel_deg  = 9'($urandom_range(1, 360));
            t             = int'($urandom_range(0, 180)) - 90;
            c.zero_offset = t[7:0];
            c.reverse     = 1'($urandom_range(0, 1));
            c.floor_deg   = lo[8:0];
            c.ceil_deg    = hi[8:0];
            if ($urandom_range(0, 2) == 0) begin
               c.width_lo_us = 16'($urandom_range(0, 65535));
               c.width_hi_us = 16'($urandom_range(0, 65535));
            end else begin
               c.width_lo_us = 16'($urandom_range(400, 1000));
               c.width_hi_us = 16'($urandom_range(2000, 2600));
            end
            c.step_per_tick = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(1, 1536));
         end
      endcase
      return c;
   endfunction

   // Mostly a new target followed by a run of ticks, with noise in between
   task automatic random_commands(int count);
      int sent, r, run, a;
      sent = 0;
      while (sent < count) begin
         r = int'($urandom_range(0, 99));
         if (r < 50) begin
            if (r < 35) begin
               a = int'($urandom_range(0, 400)) - 200;
               send_command(sspg_pkg::CMD_SET, a[9:0]);
            end else begin
               a = int'($urandom_range(0, 80)) - 40;
               send_command(sspg_pkg::CMD_ADD, a[9:0]);
            end
            sent++;
            run = int'($urandom_range(1, 24));
            repeat (run) begin
               send_command(sspg_pkg::CMD_TICK, 10'($urandom_range(0, 1023)));
               sent++;
            end
         end else if (r < 60) begin
            a = int'($urandom_range(0, 400)) - 200;
            send_command(sspg_pkg::CMD_PLACE, a[9:0]);
            sent++;
         end else if (r < 72) begin
            send_command(sspg_pkg::cmd_type'($urandom_range(0, 3)),
                         10'($urandom_range(0, 1023)));
            sent++;
         end else begin
            send_command(sspg_pkg::CMD_TICK, 10'($urandom_range(0, 1023)));
            sent++;
         end
      end
   endtask

   // Result side: take and check results, stall at random
   initial begin : result_sink
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            tracker.check_result(rsp_tdata);
         if (hold == 0 && sink_hold_request) begin
            sink_hold_request = 1'b0;
            hold = PRESSURE_CYCLES;
         end else if (hold == 0) begin
            hold = sink_idle_on ? pick_gap() : 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("servo_slew_pulse_generator verification failed");
      $finish;
   end

   initial begin : stimulus
      int p;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= sspg_pkg::CMD_TICK;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, clamping, add overflow, ignored tick angle
      send_command(sspg_pkg::CMD_TICK, 10'd0);
      send_command(sspg_pkg::CMD_PLACE, 10'h200);
      send_command(sspg_pkg::CMD_TICK, 10'h3FF);
      send_command(sspg_pkg::CMD_PLACE, 10'h1FF);
      send_command(sspg_pkg::CMD_SET, 10'h200);
      send_command(sspg_pkg::CMD_TICK, 10'h200);
      send_command(sspg_pkg::CMD_TICK, 10'h1FF);
      send_command(sspg_pkg::CMD_ADD, 10'h1FF);
      send_command(sspg_pkg::CMD_TICK, 10'd0);
      send_command(sspg_pkg::CMD_ADD, 10'h200);
      send_command(sspg_pkg::CMD_ADD, 10'h3FF);
      send_command(sspg_pkg::CMD_ADD, 10'd1);
      send_command(sspg_pkg::CMD_SET, 10'd0);
      send_command(sspg_pkg::CMD_TICK, 10'd0);
      send_command(sspg_pkg::CMD_TICK, 10'd0);
      send_command(sspg_pkg::CMD_PLACE, 10'd0);
      send_command(sspg_pkg::CMD_SET, 10'd1);
      send_command(sspg_pkg::CMD_TICK, 10'd0);
      send_command(sspg_pkg::CMD_SET, 10'h3FF);
      send_command(sspg_pkg::CMD_TICK, 10'd0);
      send_command(sspg_pkg::CMD_PLACE, 10'd45);
      send_command(sspg_pkg::CMD_SET, 10'h3D3);

      for (p = 1; p <= PHASES; p++) begin
         drain();
         apply_config(phase_config(p));
         feed_idle_on = (p == 3 || p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
         sink_idle_on = (p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
         // hold the result side off while requests keep coming
         if (p == 3) sink_hold_request = 1'b1;
         random_commands(ITEMS_PER_PHASE);
      end

      drain();
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("servo_slew_pulse_generator verification clean");
      else
         $display("servo_slew_pulse_generator verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/sspg_pkg.sv
design/sspg_divider.sv
design/servo_slew_pulse_generator.sv
tb/sv/tb.sv
